// ===== design/bll_pkg.sv =====
// ----------------------------------------------------------------------------
// bll_pkg: shared types and constants for the line lexer
// Lexer modes, token kinds, character codes and the result record.
// ----------------------------------------------------------------------------
package bll_pkg;

    // lexer modes, one-hot
    typedef enum logic [6:0] {
        MODE_IDLE = 7'b0000001,
        MODE_NAME = 7'b0000010,
        MODE_ZERO = 7'b0000100,
        MODE_DEC  = 7'b0001000,
        MODE_HEX  = 7'b0010000,
        MODE_STR  = 7'b0100000,
        MODE_OP   = 7'b1000000
    } mode_t;

    // token kinds
    localparam logic [1:0] KIND_NAME = 2'd0;
    localparam logic [1:0] KIND_NUM  = 2'd1;
    localparam logic [1:0] KIND_STR  = 2'd2;
    localparam logic [1:0] KIND_OP   = 2'd3;

    // character codes
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_LT         = 8'h3C;
    localparam logic [7:0] CH_EQ         = 8'h3D;
    localparam logic [7:0] CH_GT         = 8'h3E;
    localparam logic [7:0] CH_UP_A       = 8'h41;
    localparam logic [7:0] CH_UP_F       = 8'h46;
    localparam logic [7:0] CH_UP_X       = 8'h58;
    localparam logic [7:0] CH_UP_Z       = 8'h5A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LO_A       = 8'h61;
    localparam logic [7:0] CH_LO_F       = 8'h66;
    localparam logic [7:0] CH_LO_X       = 8'h78;
    localparam logic [7:0] CH_LO_Z       = 8'h7A;
    localparam logic [7:0] CH_HIGH       = 8'h80;

    // result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = 2;
    localparam int CNT_W       = 3;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] held_char;
        logic       held_valid;
        logic [1:0] kind;
    } lex_state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic [1:0] token_type;
        logic       token_end;
        logic       run_last;
    } result_t;

endpackage

// ===== design/bll_step.sv =====
// ----------------------------------------------------------------------------
// bll_step: one lexer step
// Next lexer state and up to two result records for one text byte.
// ----------------------------------------------------------------------------
module bll_step (
    input  bll_pkg::lex_state_t state_i,
    input  logic [7:0]          text_byte_i,
    output bll_pkg::lex_state_t state_o,
    output bll_pkg::result_t    res0_o,
    output bll_pkg::result_t    res1_o,
    output logic [1:0]          res_cnt_o
);

    logic             is_alpha;
    logic             is_digit;
    logic             is_hex;
    logic             is_white;
    logic             adv;
    logic             close;
    logic             do_start;
    logic             a_valid;
    logic             a_end;
    logic             b_valid;
    bll_pkg::result_t res_a;
    bll_pkg::result_t res_b;
    logic [7:0]       c;

    assign c = text_byte_i;

    // character classes
    always_comb begin
        is_alpha = (c >= bll_pkg::CH_UP_A && c <= bll_pkg::CH_UP_Z)
                || (c >= bll_pkg::CH_LO_A && c <= bll_pkg::CH_LO_Z)
                || (c == bll_pkg::CH_UNDERSCORE);
        is_digit = (c >= bll_pkg::CH_ZERO && c <= bll_pkg::CH_NINE);
        is_hex   = is_digit
                || (c >= bll_pkg::CH_UP_A && c <= bll_pkg::CH_UP_F)
                || (c >= bll_pkg::CH_LO_A && c <= bll_pkg::CH_LO_F);
        is_white = (c != bll_pkg::CH_NUL && c <= bll_pkg::CH_SPACE)
                || (c >= bll_pkg::CH_HIGH);
    end

    always_comb begin
        state_o  = state_i;
        adv      = 1'b0;
        close    = 1'b0;
        do_start = 1'b0;
        a_valid  = 1'b0;
        a_end    = 1'b0;
        b_valid  = 1'b0;
        res_b    = '0;

        unique case (state_i.mode)
            bll_pkg::MODE_NAME: begin
                if (is_alpha || is_digit) adv = 1'b1;
                else close = 1'b1;
            end
            bll_pkg::MODE_ZERO: begin
                if (c == bll_pkg::CH_LO_X || c == bll_pkg::CH_UP_X) begin
                    adv = 1'b1;
                    state_o.mode = bll_pkg::MODE_HEX;
                end else if (is_digit) begin
                    adv = 1'b1;
                    state_o.mode = bll_pkg::MODE_DEC;
                end else if (c == bll_pkg::CH_UNDERSCORE) begin
                    state_o.mode = bll_pkg::MODE_DEC;
                end else begin
                    close = 1'b1;
                end
            end
            bll_pkg::MODE_DEC: begin
                if (is_digit) adv = 1'b1;
                else if (c != bll_pkg::CH_UNDERSCORE) close = 1'b1;
            end
            bll_pkg::MODE_HEX: begin
                if (is_hex) adv = 1'b1;
                else if (c != bll_pkg::CH_UNDERSCORE) close = 1'b1;
            end
            bll_pkg::MODE_STR: begin
                if (c == bll_pkg::CH_NUL || c == bll_pkg::CH_QUOTE) begin
                    if (state_i.held_valid) begin
                        a_valid = 1'b1;
                        a_end   = 1'b1;
                    end else begin
                        // empty string marker
                        b_valid          = 1'b1;
                        res_b.token_type = bll_pkg::KIND_STR;
                        res_b.token_end  = 1'b1;
                    end
                    state_o.mode       = bll_pkg::MODE_IDLE;
                    state_o.held_valid = 1'b0;
                end else begin
                    adv = 1'b1;
                end
            end
            bll_pkg::MODE_OP: begin
                if (c == bll_pkg::CH_EQ) begin
                    a_valid            = state_i.held_valid;
                    b_valid            = 1'b1;
                    res_b.out_byte     = c;
                    res_b.has_byte     = 1'b1;
                    res_b.token_type   = bll_pkg::KIND_OP;
                    res_b.token_end    = 1'b1;
                    state_o.mode       = bll_pkg::MODE_IDLE;
                    state_o.held_valid = 1'b0;
                end else begin
                    close = 1'b1;
                end
            end
            default: do_start = 1'b1;
        endcase

        // pass the held character on and hold the new one
        if (adv) begin
            a_valid            = state_i.held_valid;
            state_o.held_char  = c;
            state_o.held_valid = 1'b1;
        end

        // token ended: flush the held character, then lex the byte from idle
        if (close) begin
            a_valid  = state_i.held_valid;
            a_end    = 1'b1;
            do_start = 1'b1;
        end

        if (do_start) begin
            state_o.mode       = bll_pkg::MODE_IDLE;
            state_o.held_valid = 1'b0;
            if (c == bll_pkg::CH_NUL || is_white) begin
                state_o.mode = bll_pkg::MODE_IDLE;
            end else if (is_alpha) begin
                state_o.mode       = bll_pkg::MODE_NAME;
                state_o.kind       = bll_pkg::KIND_NAME;
                state_o.held_char  = c;
                state_o.held_valid = 1'b1;
            end else if (c == bll_pkg::CH_ZERO) begin
                state_o.mode       = bll_pkg::MODE_ZERO;
                state_o.kind       = bll_pkg::KIND_NUM;
                state_o.held_char  = c;
                state_o.held_valid = 1'b1;
            end else if (is_digit) begin
                state_o.mode       = bll_pkg::MODE_DEC;
                state_o.kind       = bll_pkg::KIND_NUM;
                state_o.held_char  = c;
                state_o.held_valid = 1'b1;
            end else if (c == bll_pkg::CH_QUOTE) begin
                state_o.mode = bll_pkg::MODE_STR;
                state_o.kind = bll_pkg::KIND_STR;
            end else if (c == bll_pkg::CH_LT || c == bll_pkg::CH_GT
                      || c == bll_pkg::CH_EQ || c == bll_pkg::CH_BANG) begin
                state_o.mode       = bll_pkg::MODE_OP;
                state_o.kind       = bll_pkg::KIND_OP;
                state_o.held_char  = c;
                state_o.held_valid = 1'b1;
            end else begin
                // single-character operator goes out at once
                state_o.kind     = bll_pkg::KIND_OP;
                b_valid          = 1'b1;
                res_b.out_byte   = c;
                res_b.has_byte   = 1'b1;
                res_b.token_type = bll_pkg::KIND_OP;
                res_b.token_end  = 1'b1;
            end
        end
    end

    // held character result
    always_comb begin
        res_a.out_byte   = state_i.held_char;
        res_a.has_byte   = 1'b1;
        res_a.token_type = state_i.kind;
        res_a.token_end  = a_end;
        res_a.run_last   = !b_valid;
    end

    always_comb begin
        res1_o          = res_b;
        res1_o.run_last = 1'b1;
        res0_o          = a_valid ? res_a : res1_o;
        res_cnt_o       = {1'b0, a_valid} + {1'b0, b_valid};
    end

endmodule

// ===== design/bll_queue.sv =====
// ----------------------------------------------------------------------------
// bll_queue: result queue
// Four-entry queue taking up to two result records a cycle, giving one.
// ----------------------------------------------------------------------------
module bll_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [1:0]       push_cnt,
    input  bll_pkg::result_t push0,
    input  bll_pkg::result_t push1,
    output logic             space_ok,
    output logic             head_valid,
    output bll_pkg::result_t head,
    input  logic             head_ready
);

    bll_pkg::result_t                mem [bll_pkg::QUEUE_DEPTH];
    logic [bll_pkg::PTR_W-1:0]       wr_ptr_reg;
    logic [bll_pkg::PTR_W-1:0]       wr_ptr_next;
    logic [bll_pkg::PTR_W-1:0]       rd_ptr_reg;
    logic [bll_pkg::PTR_W-1:0]       rd_ptr_next;
    logic [bll_pkg::CNT_W-1:0]       count_reg;
    logic [bll_pkg::CNT_W-1:0]       count_next;
    logic                            pop;

    // room for two records whatever the step gives
    assign space_ok   = count_reg <= bll_pkg::CNT_W'(bll_pkg::QUEUE_DEPTH - 2);
    assign head_valid = count_reg != '0;
    assign head       = mem[rd_ptr_reg];
    assign pop        = head_valid && head_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + bll_pkg::PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + bll_pkg::PTR_W'(pop);
        count_next  = count_reg + bll_pkg::CNT_W'(push_cnt) - bll_pkg::CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            mem[wr_ptr_reg + bll_pkg::PTR_W'(1)] <= push1;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= bll_pkg::CNT_W'(bll_pkg::QUEUE_DEPTH))
        else $error("result queue count above depth");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_cnt != 2'd0 && !pop) |=>
        count_reg == $past(count_reg) + bll_pkg::CNT_W'($past(push_cnt)))
        else $error("result queue count lost a push");

endmodule

// ===== design/basic_line_lexer.sv =====
// ----------------------------------------------------------------------------
// basic_line_lexer: streaming line tokenizer
// Splits a text line, one byte per transfer, into name, number, string and
// operator tokens, at most one token character per result transfer.
// ----------------------------------------------------------------------------
// path: a byte transfer goes through the input register, then the lexer step
//   writes its results into the result queue, whose head is the result port
// throughput: one byte per cycle while bytes give at most one result each and
//   m_ready holds; a byte giving two results uses the single result port twice
// reset: aresetn, synchronous, active low; empties the input register and the
//   result queue and returns the lexer to idle with nothing held
module basic_line_lexer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_has_byte,
    output logic [1:0] m_token_type,
    output logic       m_token_end,
    output logic       m_run_last
);

    // input register
    logic                in_valid_reg;
    logic                in_valid_next;
    logic [7:0]          in_byte_reg;

    // lexer state: mode, held-back character and kind of the open token
    bll_pkg::lex_state_t state_reg;
    bll_pkg::lex_state_t state_next;

    bll_pkg::result_t    res0;
    bll_pkg::result_t    res1;
    logic [1:0]          res_cnt;
    logic [1:0]          push_cnt;
    logic                space_ok;
    logic                step_fire;
    bll_pkg::result_t    head;

    // the step runs whenever a byte waits and the queue has room for two
    // results; the input register refills in the same cycle
    assign step_fire = in_valid_reg && space_ok;
    assign s_ready   = !in_valid_reg || step_fire;
    assign push_cnt  = step_fire ? res_cnt : 2'd0;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // byte payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_text_byte;
        end
    end

    bll_step u_step (
        .state_i     (state_reg),
        .text_byte_i (in_byte_reg),
        .state_o     (state_next),
        .res0_o      (res0),
        .res1_o      (res1),
        .res_cnt_o   (res_cnt)
    );

    // lexer state advances only on a stepped byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode       <= bll_pkg::MODE_IDLE;
            state_reg.held_char  <= '0;
            state_reg.held_valid <= 1'b0;
            state_reg.kind       <= bll_pkg::KIND_NAME;
        end else if (step_fire) begin
            state_reg <= state_next;
        end
    end

    // result queue parts the step from the result port
    bll_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_cnt   (push_cnt),
        .push0      (res0),
        .push1      (res1),
        .space_ok   (space_ok),
        .head_valid (m_valid),
        .head       (head),
        .head_ready (m_ready)
    );

    assign m_out_byte   = head.out_byte;
    assign m_has_byte   = head.has_byte;
    assign m_token_type = head.token_type;
    assign m_token_end  = head.token_end;
    assign m_run_last   = head.run_last;

    // a held character only exists inside a token
    a_idle_nothing_held: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.held_valid |-> state_reg.mode != bll_pkg::MODE_IDLE)
        else $error("held character while idle");

    // names, numbers and paired operators always hold their last character
    a_token_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.mode == bll_pkg::MODE_NAME || state_reg.mode == bll_pkg::MODE_ZERO
         || state_reg.mode == bll_pkg::MODE_DEC || state_reg.mode == bll_pkg::MODE_HEX
         || state_reg.mode == bll_pkg::MODE_OP) |-> state_reg.held_valid)
        else $error("open token without held character");

endmodule

// ===== test/lexer_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lexer_checker: token stream predictor and scoreboard for the line lexer
// Watches both channels. Every byte transfer is run through a local copy
// of the lexer, and the token characters it gives are queued. Every result
// transfer is checked field by field against the oldest queued character.
// ----------------------------------------------------------------------------
module lexer_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_text_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte,
    input  logic       m_has_byte,
    input  logic [1:0] m_token_type,
    input  logic       m_token_end,
    input  logic       m_run_last,
    output int         fail_count,
    output int         pending,
    output int         checked
);

    localparam int MAX_PRINTED = 40;

    // local lexer state
    bll_pkg::mode_t   lx_mode;
    logic [7:0]       lx_held;
    logic             lx_held_ok;
    logic [1:0]       lx_kind;

    // results of one byte, then the queue of expected token characters
    bll_pkg::result_t step_buf [2];
    int               step_n;
    bll_pkg::result_t token_q [$];
    bll_pkg::result_t want;
    int               err_total = 0;
    int               result_idx = 0;

    // '_' counts as a letter
    function automatic bit is_letter(logic [7:0] c);
        return (c >= bll_pkg::CH_UP_A && c <= bll_pkg::CH_UP_Z) ||
               (c >= bll_pkg::CH_LO_A && c <= bll_pkg::CH_LO_Z) ||
               c == bll_pkg::CH_UNDERSCORE;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= bll_pkg::CH_ZERO && c <= bll_pkg::CH_NINE;
    endfunction

    function automatic bit is_hex_digit(logic [7:0] c);
        return is_digit(c) || (c >= bll_pkg::CH_UP_A && c <= bll_pkg::CH_UP_F) ||
               (c >= bll_pkg::CH_LO_A && c <= bll_pkg::CH_LO_F);
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return (c != bll_pkg::CH_NUL && c <= bll_pkg::CH_SPACE) || c >= bll_pkg::CH_HIGH;
    endfunction

    function void put_res(logic [7:0] b, logic has, logic [1:0] kind, logic fin);
        if (step_n < 2) begin
            step_buf[step_n].out_byte   = b;
            step_buf[step_n].has_byte   = has;
            step_buf[step_n].token_type = kind;
            step_buf[step_n].token_end  = fin;
            step_buf[step_n].run_last   = 1'b0;
            step_n++;
        end
    endfunction

    function void flush_held(logic fin);
        if (lx_held_ok)
            put_res(lx_held, 1'b1, lx_kind, fin);
        lx_held_ok = 1'b0;
    endfunction

    function void hold_char(logic [7:0] c);
        lx_held    = c;
        lx_held_ok = 1'b1;
    endfunction

    // byte seen with no token open
    function void open_token(logic [7:0] c);
        lx_mode    = bll_pkg::MODE_IDLE;
        lx_held_ok = 1'b0;
        if (c == bll_pkg::CH_NUL || is_space(c)) begin
            // skipped
        end else if (is_letter(c)) begin
            lx_mode = bll_pkg::MODE_NAME;
            lx_kind = bll_pkg::KIND_NAME;
            hold_char(c);
        end else if (c == bll_pkg::CH_ZERO) begin
            lx_mode = bll_pkg::MODE_ZERO;
            lx_kind = bll_pkg::KIND_NUM;
            hold_char(c);
        end else if (is_digit(c)) begin
            lx_mode = bll_pkg::MODE_DEC;
            lx_kind = bll_pkg::KIND_NUM;
            hold_char(c);
        end else if (c == bll_pkg::CH_QUOTE) begin
            lx_mode = bll_pkg::MODE_STR;
            lx_kind = bll_pkg::KIND_STR;
        end else if (c == bll_pkg::CH_LT || c == bll_pkg::CH_GT ||
                     c == bll_pkg::CH_EQ || c == bll_pkg::CH_BANG) begin
            lx_mode = bll_pkg::MODE_OP;
            lx_kind = bll_pkg::KIND_OP;
            hold_char(c);
        end else begin
            lx_kind = bll_pkg::KIND_OP;
            put_res(c, 1'b1, bll_pkg::KIND_OP, 1'b1);
        end
    endfunction

    function void close_open(logic [7:0] c);
        flush_held(1'b1);
        open_token(c);
    endfunction

    function void shift_in(logic [7:0] c);
        flush_held(1'b0);
        hold_char(c);
    endfunction

    function void lex_step(logic [7:0] c);
        step_n = 0;
        case (lx_mode)
            bll_pkg::MODE_NAME: begin
                if (is_letter(c) || is_digit(c))
                    shift_in(c);
                else
                    close_open(c);
            end
            bll_pkg::MODE_ZERO: begin
                if (c == bll_pkg::CH_LO_X || c == bll_pkg::CH_UP_X) begin
                    shift_in(c);
                    lx_mode = bll_pkg::MODE_HEX;
                end else if (is_digit(c)) begin
                    shift_in(c);
                    lx_mode = bll_pkg::MODE_DEC;
                end else if (c == bll_pkg::CH_UNDERSCORE) begin
                    lx_mode = bll_pkg::MODE_DEC;
                end else begin
                    close_open(c);
                end
            end
            bll_pkg::MODE_DEC: begin
                if (is_digit(c))
                    shift_in(c);
                else if (c != bll_pkg::CH_UNDERSCORE)
                    close_open(c);
            end
            bll_pkg::MODE_HEX: begin
                if (is_hex_digit(c))
                    shift_in(c);
                else if (c != bll_pkg::CH_UNDERSCORE)
                    close_open(c);
            end
            bll_pkg::MODE_STR: begin
                if (c == bll_pkg::CH_NUL || c == bll_pkg::CH_QUOTE) begin
                    if (lx_held_ok)
                        flush_held(1'b1);
                    else
                        put_res(bll_pkg::CH_NUL, 1'b0, bll_pkg::KIND_STR, 1'b1);
                    lx_mode = bll_pkg::MODE_IDLE;
                end else begin
                    shift_in(c);
                end
            end
            bll_pkg::MODE_OP: begin
                if (c == bll_pkg::CH_EQ) begin
                    flush_held(1'b0);
                    put_res(c, 1'b1, bll_pkg::KIND_OP, 1'b1);
                    lx_mode = bll_pkg::MODE_IDLE;
                end else begin
                    close_open(c);
                end
            end
            default: open_token(c);
        endcase
        if (step_n > 0)
            step_buf[step_n - 1].run_last = 1'b1;
        for (int i = 0; i < step_n; i++)
            token_q.push_back(step_buf[i]);
    endfunction

    task report_mismatch(input string msg);
        if (err_total < MAX_PRINTED)
            $display("[%0t] token mismatch: %s", $time, msg);
        err_total++;
    endtask

    task check_field(input string fname, input int got, input int exp_v);
        if (got != exp_v)
            report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                      result_idx, fname, got, exp_v));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            lx_mode    = bll_pkg::MODE_IDLE;
            lx_held    = bll_pkg::CH_NUL;
            lx_held_ok = 1'b0;
            lx_kind    = bll_pkg::KIND_NAME;
            token_q.delete();
        end else begin
            // byte first: its results can never come out at the same edge
            if (s_valid && s_ready)
                lex_step(s_text_byte);
            if (m_valid && m_ready) begin
                if (token_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d (0x%02h) with nothing expected",
                                              result_idx, m_out_byte));
                end else begin
                    want = token_q.pop_front();
                    check_field("out_byte",   int'(m_out_byte),   int'(want.out_byte));
                    check_field("has_byte",   int'(m_has_byte),   int'(want.has_byte));
                    check_field("token_type", int'(m_token_type), int'(want.token_type));
                    check_field("token_end",  int'(m_token_end),  int'(want.token_end));
                    check_field("run_last",   int'(m_run_last),   int'(want.run_last));
                end
                result_idx++;
            end
        end
        pending    <= token_q.size();
        fail_count <= err_total;
        checked    <= result_idx;
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the line lexer
// Feeds a short hand-picked line set, then random lines built from names,
// numbers, strings and operators with noise mixed in, with random idling on
// both channels. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT  = 2000;  // quiet cycles before giving up
    localparam int RX_STALL_CYCLES = 300;   // long result hold-off
    localparam int DRAIN_CYCLES    = 10;    // settle time after the last result
    localparam int ITEM_TARGET     = 950;   // byte transfers the run reaches at least
    localparam int IDLE_PCT        = 34;    // idle cycles per hundred, each side

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_text_byte;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic       m_has_byte;
    logic [1:0] m_token_type;
    logic       m_token_end;
    logic       m_run_last;

    int fail_count;
    int pending;
    int checked;

    bit gaps_on;          // random idling on both sides
    bit rx_stall_req;     // asks the receiver for one long hold-off
    int quiet_cycles;
    int sent_bytes;
    int token_bytes;

    logic [7:0] line_q [$];
    logic [7:0] opening_bytes [25];

    // character pools for the random lines
    string name_head = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_";
    string name_body = "ABCXYZabcfxz_0123456789";
    string dec_body  = "0123456789_";
    string hex_body  = "0123456789abcdefABCDEF_gG";
    string hex_mark  = "xX";
    string str_body  = "ab Z9_ +=<!\t.,x0";
    string op_chars  = "+-*/%()[]{},;:.&|^~?@#$'<>=!<>=!";

    basic_line_lexer uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_text_byte  (s_text_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_has_byte   (m_has_byte),
        .m_token_type (m_token_type),
        .m_token_end  (m_token_end),
        .m_run_last   (m_run_last)
    );

    // predicts and compares, hands back failure and backlog counts
    lexer_checker token_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_text_byte  (s_text_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_has_byte   (m_has_byte),
        .m_token_type (m_token_type),
        .m_token_end  (m_token_end),
        .m_run_last   (m_run_last),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: random back-pressure, a steady stretch, one long hold-off
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_stall_req) begin
                stall_left   = RX_STALL_CYCLES;
                rx_stall_req = 1'b0;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (!gaps_on) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // watchdog: any transfer on either channel resets the count
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results pending",
                         quiet_cycles, pending);
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic logic [7:0] pick(string chars);
        return chars[$urandom_range(chars.len() - 1)];
    endfunction

    // one byte transfer; random idle cycles before it drop valid,
    // back-to-back bytes keep valid high and only swap the payload
    task send_byte(input logic [7:0] b);
        if (gaps_on) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid     <= 1'b1;
        s_text_byte <= b;
        do
            @(posedge aclk);
        while (!s_ready);
        sent_bytes++;
    endtask

    // one token with random content, now and then malformed
    task automatic append_token(input logic [1:0] kind);
        int start_size;
        logic [7:0] c;
        start_size = line_q.size();
        case (kind)
            bll_pkg::KIND_NAME: begin
                line_q.push_back(pick(name_head));
                repeat ($urandom_range(0, 5)) line_q.push_back(pick(name_body));
            end
            bll_pkg::KIND_NUM: begin
                if ($urandom_range(1)) begin
                    // decimal, may start with 0 and carry underscores
                    line_q.push_back(pick(dec_body));
                    repeat ($urandom_range(0, 4)) line_q.push_back(pick(dec_body));
                end else begin
                    // hex prefix, digits optional
                    line_q.push_back(bll_pkg::CH_ZERO);
                    line_q.push_back(pick(hex_mark));
                    repeat ($urandom_range(0, 4)) line_q.push_back(pick(hex_body));
                end
            end
            bll_pkg::KIND_STR: begin
                line_q.push_back(bll_pkg::CH_QUOTE);
                repeat ($urandom_range(0, 5)) begin
                    if ($urandom_range(3) == 0)
                        c = 8'($urandom_range(1, 255));
                    else
                        c = pick(str_body);
                    if (c == bll_pkg::CH_QUOTE)
                        c = bll_pkg::CH_SPACE;
                    line_q.push_back(c);
                end
                // now and then left open, so the rest of the line joins it
                if ($urandom_range(99) < 85)
                    line_q.push_back(bll_pkg::CH_QUOTE);
            end
            default: begin
                line_q.push_back(pick(op_chars));
                if ($urandom_range(1))
                    line_q.push_back(bll_pkg::CH_EQ);
            end
        endcase
        token_bytes += line_q.size() - start_size;
    endtask

    // a line of tokens with mixed separators, or a burst of raw noise
    task automatic append_line();
        int n_noise;
        logic [1:0] kind;
        if ($urandom_range(9) == 0) begin
            n_noise = $urandom_range(1, 10);
            repeat (n_noise) line_q.push_back(8'($urandom_range(255)));
            token_bytes += n_noise;
        end else begin
            repeat ($urandom_range(1, 5)) begin
                // no separator at all a quarter of the time, so the tokens touch
                case ($urandom_range(3))
                    0: ;
                    1: line_q.push_back(bll_pkg::CH_SPACE);
                    2: line_q.push_back(8'($urandom_range(1, bll_pkg::CH_SPACE)));
                    default: line_q.push_back(8'($urandom_range(bll_pkg::CH_HIGH, 255)));
                endcase
                kind = 2'($urandom_range(3));
                append_token(kind);
            end
        end
        line_q.push_back(bll_pkg::CH_NUL);
    endtask

    initial begin
        bit stall_done;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_text_byte  = bll_pkg::CH_NUL;
        gaps_on      = 1'b1;
        rx_stall_req = 1'b0;
        stall_done   = 1'b0;
        sent_bytes   = 0;
        token_bytes  = 0;
        quiet_cycles = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // hand-picked opening: a_9, high-byte gap, lone 0x closed by +,
        // 0_1, empty string, <=, ! then name, DEL operator, unterminated
        // string, empty line, single digit cut by end of line
        opening_bytes = '{8'h61, 8'h5F, 8'h39, 8'h80, 8'h30, 8'h78, 8'h2B,
                          8'h30, 8'h5F, 8'h31, 8'hFF, 8'h22, 8'h22, 8'h3C,
                          8'h3D, 8'h20, 8'h21, 8'h78, 8'h7F, 8'h22, 8'h73,
                          8'h00, 8'h00, 8'h37, 8'h00};
        foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

        // sender pauses until the whole backlog is out
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (pending != 0);

        while (sent_bytes < ITEM_TARGET) begin
            // steady stretch with no idling on either side
            gaps_on = !(sent_bytes >= 300 && sent_bytes < 450);
            // one long result hold-off while bytes keep coming
            if (!stall_done && sent_bytes >= 600) begin
                rx_stall_req = 1'b1;
                stall_done   = 1'b1;
            end
            append_line();
            foreach (line_q[i]) send_byte(line_q[i]);
            line_q.delete();
        end
        s_valid <= 1'b0;

        do
            @(posedge aclk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("ran %0d bytes (%0d in tokens or noise): names, numbers, strings,",
                 sent_bytes, token_bytes);
        $display("operators and line ends; %0d results checked through stalls and gaps",
                 checked);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/bll_pkg.sv
design/bll_step.sv
design/bll_queue.sv
design/basic_line_lexer.sv
test/lexer_checker.sv
test/tb_top.sv
